/* hw/rtl/itic_pkg.sv */
// shared types and constants of the interrupt table integrity checker
package itic_pkg;

  localparam int unsigned AddrW           = 64;
  localparam int unsigned VecW            = 8;
  localparam int unsigned CountW          = 9;
  localparam int unsigned LimitW          = 16;
  localparam int unsigned CfgIdxW         = 2;
  localparam int unsigned DefTableEntries = 256;
  localparam int unsigned DefEntryBytes   = 16;

  localparam logic [LimitW-1:0] LimitReset = 16'd4095;
  localparam logic [CountW-1:0] CountMax   = 9'd511;

  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdCheck = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTextStart = 2'd0,
    CfgTextEnd   = 2'd1,
    CfgTableBase = 2'd2,
    CfgByteLimit = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [VecW-1:0]  vector;
    logic [AddrW-1:0] address;
    logic             present;
    logic             last;
    logic             armed;
  } item_t;

  typedef struct packed {
    logic             present;
    logic [AddrW-1:0] address;
  } snap_t;

  typedef struct packed {
    logic [AddrW-1:0] text_start;
    logic [AddrW-1:0] text_end;
    logic [AddrW-1:0] table_base;
  } cfg_t;

endpackage

/* hw/rtl/itic_snapshot_mem.sv */
// snapshot memory of gate addresses and present bits, with per-entry valid bits
module itic_snapshot_mem import itic_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = DefTableEntries,
  parameter int unsigned ENTRY_BYTES   = DefEntryBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  item_t             item_i,
  input  logic [LimitW-1:0] byte_limit_i,
  output snap_t             snap_o
);

  localparam int unsigned IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SpanW = LimitW + 1;

  snap_t                    mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_q;
  snap_t                    rd_q;
  logic                     rd_vld_q;

  logic [IdxW-1:0]  idx;
  logic             in_table;
  logic             in_range;
  logic [SpanW-1:0] entry_end;
  logic [SpanW-1:0] limit_end;
  logic             wr_en;
  snap_t            wr_data;

  assign idx       = item_i.vector[IdxW-1:0];
  assign in_table  = {1'b0, item_i.vector} < 9'(TABLE_ENTRIES);
  assign entry_end = SpanW'((SpanW'(item_i.vector) + SpanW'(1)) * SpanW'(ENTRY_BYTES));
  assign limit_end = SpanW'(byte_limit_i) + SpanW'(1);
  assign in_range  = entry_end <= limit_end;
  assign wr_en     = accept_i && (item_i.cmd == CmdLoad) && in_table;

  always_comb begin
    wr_data = '0;
    if (in_range) begin
      wr_data.present = item_i.present;
      wr_data.address = item_i.address;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[idx] <= wr_data;
    end
    if (accept_i) begin
      rd_q <= mem_q[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[idx] <= 1'b1;
      end
      if (accept_i) begin
        rd_vld_q <= in_table && vld_q[idx];
      end
    end
  end

  assign snap_o = rd_vld_q ? rd_q : '0;

endmodule

/* hw/rtl/itic_compare.sv */
// compare stage: snapshot versus live gate, pass count and output register
module itic_compare import itic_pkg::*; #(
  parameter int unsigned ENTRY_BYTES = DefEntryBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  item_t             item_i,
  input  snap_t             snap_i,
  input  cfg_t              cfg_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              changed_o,
  output logic              hook_alert_o,
  output logic [AddrW-1:0]  alert_location_o,
  output logic [VecW-1:0]   alert_vector_o,
  output logic [CountW-1:0] changed_count_o,
  output logic              pass_done_o
);

  item_t             s1_q;
  logic              s1_valid_q;
  logic              out_valid_q;
  logic [CountW-1:0] pass_q;

  logic              advance;
  logic              accept;
  logic              active;
  logic              differs;
  logic              outside;
  logic [CountW-1:0] cnt_next;

  logic              changed_d, changed_q;
  logic              alert_d, alert_q;
  logic [AddrW-1:0]  loc_d, loc_q;
  logic [VecW-1:0]   vec_q;
  logic [CountW-1:0] count_d, count_q;
  logic              done_d, done_q;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  assign active   = (s1_q.cmd == CmdCheck) && s1_q.armed;
  assign differs  = (snap_i.present || s1_q.present) && (snap_i.address != s1_q.address);
  assign outside  = (s1_q.address < cfg_i.text_start) || (s1_q.address >= cfg_i.text_end);
  assign cnt_next = (differs && (pass_q != CountMax)) ? pass_q + CountW'(1) : pass_q;

  always_comb begin
    changed_d = active && differs;
    alert_d   = changed_d && outside;
    loc_d     = '0;
    if (alert_d) begin
      loc_d = cfg_i.table_base + AddrW'(s1_q.vector) * AddrW'(ENTRY_BYTES);
    end
    count_d = active ? cnt_next : '0;
    done_d  = ((s1_q.cmd == CmdLoad) || s1_q.armed) && s1_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= item_i;
    end
    if (advance) begin
      changed_q <= changed_d;
      alert_q   <= alert_d;
      loc_q     <= loc_d;
      vec_q     <= s1_q.vector;
      count_q   <= count_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pass_q      <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance && active) begin
        pass_q <= s1_q.last ? '0 : cnt_next;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign changed_o        = changed_q;
  assign hook_alert_o     = alert_q;
  assign alert_location_o = loc_q;
  assign alert_vector_o   = vec_q;
  assign changed_count_o  = count_q;
  assign pass_done_o      = done_q;

endmodule

/* hw/rtl/interrupt_table_integrity_check_top.sv */
// top level of the interrupt table integrity checker
//
// Input channel (in_valid_i/in_ready_o) carries one gate request: a load writes
// a snapshot entry, a check compares a live gate with its snapshot. A load with
// last set arms the block; checks before that report only the vector.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes text_start, text_end,
// table_base_location and table_byte_limit by index; it is always ready.
// Output channel (out_valid_o/out_ready_i) gives exactly one result per request.
// Path: an accepted request reads its snapshot entry into the memory read register
// alongside the compare stage, then is compared into the output register.
// Throughput: one request per cycle while results are taken, set by the single
// snapshot memory port; loads write at the accept edge so a following check
// always reads fresh data. When the receiver stalls, the output register and the
// compare stage hold and in_ready_o drops once both are full; nothing is lost.
// Reset clears the valid bits of all snapshot entries (unwritten entries read
// as zero and not present), disarms the block, clears the pass count and puts
// the configuration registers back to their defaults, with no sweep.
module interrupt_table_integrity_check_top import itic_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = DefTableEntries,
  parameter int unsigned ENTRY_BYTES   = DefEntryBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AddrW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [VecW-1:0]    vector_i,
  input  logic [AddrW-1:0]   handler_address_i,
  input  logic               present_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               changed_o,
  output logic               hook_alert_o,
  output logic [AddrW-1:0]   alert_location_o,
  output logic [VecW-1:0]    alert_vector_o,
  output logic [CountW-1:0]  changed_count_o,
  output logic               pass_done_o
);

  cfg_t              cfg_q;
  logic [LimitW-1:0] limit_q;
  logic              armed_q;
  item_t             item;
  snap_t             snap;
  logic              accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    item.cmd     = cmd_e'(command_i);
    item.vector  = vector_i;
    item.address = handler_address_i;
    item.present = present_i;
    item.last    = last_i;
    item.armed   = armed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      limit_q <= LimitReset;
      armed_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          CfgTextStart: cfg_q.text_start <= cfg_data_i;
          CfgTextEnd:   cfg_q.text_end   <= cfg_data_i;
          CfgTableBase: cfg_q.table_base <= cfg_data_i;
          CfgByteLimit: limit_q          <= cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end
      if (accept && (item.cmd == CmdLoad) && last_i) begin
        armed_q <= 1'b1;
      end
    end
  end

  itic_snapshot_mem #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ENTRY_BYTES  (ENTRY_BYTES)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item),
    .byte_limit_i(limit_q),
    .snap_o      (snap)
  );

  itic_compare #(
    .ENTRY_BYTES(ENTRY_BYTES)
  ) u_cmp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .item_i          (item),
    .snap_i          (snap),
    .cfg_i           (cfg_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .changed_o       (changed_o),
    .hook_alert_o    (hook_alert_o),
    .alert_location_o(alert_location_o),
    .alert_vector_o  (alert_vector_o),
    .changed_count_o (changed_count_o),
    .pass_done_o     (pass_done_o)
  );

endmodule

/* sim/tb.sv */
// self-checking testbench for the interrupt table integrity checker top level
module tb;
  import itic_pkg::*;

  typedef struct packed {
    logic              changed;
    logic              hook_alert;
    logic [AddrW-1:0]  location;
    logic [VecW-1:0]   vector;
    logic [CountW-1:0] count;
    logic              pass_done;
  } gate_result_t;

  class snapshot_scoreboard;
    logic [AddrW-1:0]  saved_addr [DefTableEntries];
    logic              saved_pres [DefTableEntries];
    bit                armed;
    logic [CountW-1:0] pass_changes;
    logic [AddrW-1:0]  text_lo;
    logic [AddrW-1:0]  text_hi;
    logic [AddrW-1:0]  table_base;
    logic [LimitW-1:0] byte_limit;
    gate_result_t      awaited_results [$];
    int unsigned       errors;

    function new();
      foreach (saved_addr[i]) begin
        saved_addr[i] = '0;
        saved_pres[i] = 1'b0;
      end
      armed        = 1'b0;
      pass_changes = '0;
      text_lo      = '0;
      text_hi      = '0;
      table_base   = '0;
      byte_limit   = LimitReset;
      errors       = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [AddrW-1:0] data);
      case (idx)
        CfgTextStart: text_lo = data;
        CfgTextEnd:   text_hi = data;
        CfgTableBase: table_base = data;
        CfgByteLimit: byte_limit = data[LimitW-1:0];
        default: ;
      endcase
    endfunction

    function void note_gate(cmd_e cmd, logic [VecW-1:0] vec, logic [AddrW-1:0] addr,
                            logic pres, logic is_last);
      gate_result_t r;
      int unsigned  usable;
      r = '0;
      r.vector = vec;
      usable = (int'(byte_limit) + 1) / DefEntryBytes;
      if (usable > DefTableEntries) usable = DefTableEntries;
      if (cmd == CmdLoad) begin
        if (vec < usable) begin
          saved_addr[vec] = addr;
          saved_pres[vec] = pres;
        end else begin
          saved_addr[vec] = '0;
          saved_pres[vec] = 1'b0;
        end
        if (is_last) armed = 1'b1;
        r.pass_done = is_last;
      end else if (armed) begin
        if ((saved_pres[vec] | pres) && saved_addr[vec] != addr) begin
          r.changed = 1'b1;
          if (pass_changes < CountMax) pass_changes++;
          if (addr < text_lo || addr >= text_hi) begin
            r.hook_alert = 1'b1;
            r.location = table_base + AddrW'(vec) * AddrW'(DefEntryBytes);
          end
        end
        r.count = pass_changes;
        r.pass_done = is_last;
        if (is_last) pass_changes = '0;
      end
      awaited_results.push_back(r);
    endfunction

    function void check_result(gate_result_t got);
      gate_result_t exp;
      if (awaited_results.size() == 0) begin
        $error("result for vector %0d with no request pending", got.vector);
        errors++;
        return;
      end
      exp = awaited_results.pop_front();
      if (got.changed !== exp.changed) begin
        $error("changed: expected %0d, got %0d", exp.changed, got.changed);
        errors++;
      end
      if (got.hook_alert !== exp.hook_alert) begin
        $error("hook_alert: expected %0d, got %0d", exp.hook_alert, got.hook_alert);
        errors++;
      end
      if (got.location !== exp.location) begin
        $error("alert_location: expected %h, got %h", exp.location, got.location);
        errors++;
      end
      if (got.vector !== exp.vector) begin
        $error("alert_vector: expected %0d, got %0d", exp.vector, got.vector);
        errors++;
      end
      if (got.count !== exp.count) begin
        $error("changed_count: expected %0d, got %0d", exp.count, got.count);
        errors++;
      end
      if (got.pass_done !== exp.pass_done) begin
        $error("pass_done: expected %0d, got %0d", exp.pass_done, got.pass_done);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [AddrW-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               command_i;
  logic [VecW-1:0]    vector_i;
  logic [AddrW-1:0]   handler_address_i;
  logic               present_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               changed_o;
  logic               hook_alert_o;
  logic [AddrW-1:0]   alert_location_o;
  logic [VecW-1:0]    alert_vector_o;
  logic [CountW-1:0]  changed_count_o;
  logic               pass_done_o;

  bit calm;
  snapshot_scoreboard sb = new();

  interrupt_table_integrity_check_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .vector_i         (vector_i),
    .handler_address_i(handler_address_i),
    .present_i        (present_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .changed_o        (changed_o),
    .hook_alert_o     (hook_alert_o),
    .alert_location_o (alert_location_o),
    .alert_vector_o   (alert_vector_o),
    .changed_count_o  (changed_count_o),
    .pass_done_o      (pass_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #9_600_000;
    $display("[interrupt_table_integrity_check_top] ERROR");
    $finish;
  end

  // result side: random stalls, with long stretches of none
  initial begin
    int unsigned n;
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!calm) begin
        case ($urandom_range(0, 15))
          0, 1: begin
            n = $urandom_range(1, 15);
            repeat (n) begin
              out_ready_i <= 1'b0;
              @(negedge clk_i);
            end
            out_ready_i <= 1'b1;
          end
          2: repeat ($urandom_range(30, 120)) @(negedge clk_i);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result('{changed_o, hook_alert_o, alert_location_o, alert_vector_o,
                        changed_count_o, pass_done_o});
    end
  end

  function automatic logic [AddrW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [AddrW-1:0] pick_address();
    logic [AddrW-1:0] span;
    span = sb.text_hi - sb.text_lo;
    case ($urandom_range(0, 7))
      0: return sb.text_lo;
      1: return sb.text_hi;
      2: return sb.text_hi - 1;
      3: return sb.text_lo - 1;
      4: return (sb.text_hi > sb.text_lo) ? sb.text_lo + rand64() % span : rand64();
      5: return '0;
      6: return '1;
      default: return rand64();
    endcase
  endfunction

  task automatic write_cfg(cfg_reg_e idx, logic [AddrW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_gate(cmd_e cmd, logic [VecW-1:0] vec, logic [AddrW-1:0] addr,
                           logic pres, logic is_last);
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    command_i         <= cmd;
    vector_i          <= vec;
    handler_address_i <= addr;
    present_i         <= pres;
    last_i            <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_gate(cmd, vec, addr, pres, is_last);
  endtask

  task automatic hold_input(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 9) == 0) hold_input($urandom_range(1, 15));
  endtask

  // stop sending until every request has its result
  task automatic drain();
    hold_input(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic shuffle_config();
    logic [AddrW-1:0] lo;
    logic [AddrW-1:0] hi;
    logic [AddrW-1:0] base;
    logic [LimitW-1:0] lim;
    case ($urandom_range(0, 5))
      0: begin lo = '0; hi = '1; end
      1: begin lo = '1; hi = '0; end
      2: begin lo = '0; hi = '0; end
      default: begin
        lo = rand64();
        hi = lo + {32'd0, $urandom};
      end
    endcase
    case ($urandom_range(0, 3))
      0: base = '0;
      1: base = '1;
      default: base = rand64();
    endcase
    case ($urandom_range(0, 7))
      0: lim = '0;
      1: lim = 16'd15;
      2: lim = 16'd16;
      3: lim = 16'd4094;
      4: lim = 16'd4095;
      5: lim = '1;
      default: lim = LimitW'($urandom_range(0, 65535));
    endcase
    write_cfg(CfgTextStart, lo);
    write_cfg(CfgTextEnd, hi);
    write_cfg(CfgTableBase, base);
    write_cfg(CfgByteLimit, AddrW'(lim));
  endtask

  task automatic load_pass(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_gate(CmdLoad, VecW'($urandom_range(0, 255)), pick_address(),
                $urandom_range(0, 3) != 0, i == n - 1);
      maybe_pause();
    end
  endtask

  task automatic check_pass(int unsigned n);
    logic [VecW-1:0]  v;
    logic [AddrW-1:0] a;
    logic             p;
    for (int unsigned i = 0; i < n; i++) begin
      v = VecW'($urandom_range(0, 255));
      a = ($urandom_range(0, 9) < 6) ? sb.saved_addr[v] : pick_address();
      p = ($urandom_range(0, 9) < 7) ? sb.saved_pres[v] : 1'($urandom_range(0, 1));
      send_gate(CmdCheck, v, a, p, i == n - 1);
      maybe_pause();
    end
  endtask

  task automatic mixed_items(int unsigned n);
    repeat (n) begin
      send_gate(cmd_e'($urandom_range(0, 1)), VecW'($urandom_range(0, 255)), pick_address(),
                1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
      maybe_pause();
    end
  endtask

  initial begin
    int unsigned w;
    rst_ni            = 1'b0;
    calm              = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = CfgTextStart;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    command_i         = CmdLoad;
    vector_i          = '0;
    handler_address_i = '0;
    present_i         = 1'b0;
    last_i            = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // unarmed checks and an unarmed load
    send_gate(CmdCheck, 8'd3, '1, 1'b1, 1'b1);
    send_gate(CmdLoad, 8'd0, 64'h77, 1'b1, 1'b0);
    send_gate(CmdCheck, 8'd0, 64'h99, 1'b1, 1'b0);
    drain();
    write_cfg(CfgTextStart, 64'h1000);
    write_cfg(CfgTextEnd, 64'h2000);
    write_cfg(CfgTableBase, 64'hFFFF_FFFF_FFFF_FFE0);
    write_cfg(CfgByteLimit, 64'd63);

    // four usable entries; vectors 4 and 255 are stored as zero
    send_gate(CmdLoad, 8'd0, 64'h1800, 1'b1, 1'b0);
    send_gate(CmdLoad, 8'd1, 64'h0, 1'b0, 1'b0);
    send_gate(CmdLoad, 8'd3, '1, 1'b1, 1'b0);
    send_gate(CmdLoad, 8'd4, 64'h1234, 1'b1, 1'b0);
    send_gate(CmdLoad, 8'd255, 64'h5555_AAAA_5555_AAAA, 1'b1, 1'b1);
    send_gate(CmdCheck, 8'd0, 64'h1800, 1'b1, 1'b0);
    send_gate(CmdCheck, 8'd0, 64'h1FFF, 1'b1, 1'b0);
    send_gate(CmdCheck, 8'd0, 64'h2000, 1'b1, 1'b0);
    send_gate(CmdCheck, 8'd0, 64'h1000, 1'b0, 1'b0);
    send_gate(CmdCheck, 8'd0, 64'hFFF, 1'b1, 1'b0);
    send_gate(CmdCheck, 8'd1, 64'h5, 1'b0, 1'b0);
    send_gate(CmdCheck, 8'd4, 64'h1234, 1'b1, 1'b0);
    send_gate(CmdCheck, 8'd255, 64'h0, 1'b1, 1'b0);
    send_gate(CmdCheck, 8'd255, '1, 1'b0, 1'b0);
    send_gate(CmdCheck, 8'd3, 64'h0, 1'b0, 1'b1);
    // reload while armed
    send_gate(CmdLoad, 8'd2, 64'h1500, 1'b1, 1'b0);
    send_gate(CmdCheck, 8'd2, 64'h1500, 1'b1, 1'b0);
    send_gate(CmdCheck, 8'd2, 64'h1501, 1'b1, 1'b1);

    for (int ph = 0; ph < 14; ph++) begin
      if (ph >= 12) calm = 1'b1;
      drain();
      shuffle_config();
      load_pass($urandom_range(8, 64));
      repeat ($urandom_range(2, 3)) check_pass($urandom_range(10, 40));
      mixed_items($urandom_range(5, 20));
      if (ph == 5) begin
        // one long pass of changed entries drives the count into saturation
        for (int unsigned i = 0; i < 530; i++) begin
          w = $urandom_range(0, 255);
          send_gate(CmdCheck, VecW'(w), ~sb.saved_addr[w], 1'b1, i == 529);
          maybe_pause();
        end
      end
    end
    hold_input(1);

    for (w = 0; w < 5000 && sb.pending() != 0; w++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[interrupt_table_integrity_check_top] OK");
    end else begin
      $display("[interrupt_table_integrity_check_top] ERROR");
    end
    $finish;
  end

endmodule
